### hdl/tftp_read_client_control_unit_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef TFTP_READ_CLIENT_CONTROL_UNIT_ASSERT_SVH
`define TFTP_READ_CLIENT_CONTROL_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFTPRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TFTPRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/tftprc_pkg.sv
package tftprc_pkg;

	// Input operation codes
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_PACKET = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	// TFTP packet opcodes
	localparam logic [15:0] TFTP_DATA  = 16'd3;
	localparam logic [15:0] TFTP_ERROR = 16'd5;

	// Header sizes in bytes
	localparam logic [10:0] HDR_BYTES     = 11'd4;
	localparam logic [10:0] ERR_MIN_BYTES = 11'd2;

	// Result action codes
	localparam logic [2:0] ACT_RRQ     = 3'd0;
	localparam logic [2:0] ACT_DELIVER = 3'd1;
	localparam logic [2:0] ACT_ACK     = 3'd2;
	localparam logic [2:0] ACT_REBIND  = 3'd3;
	localparam logic [2:0] ACT_DONE    = 3'd4;
	localparam logic [2:0] ACT_FAIL    = 3'd5;

	// Failure reasons
	localparam logic [1:0] WHY_TIMEOUT = 2'd0;
	localparam logic [1:0] WHY_ERROR   = 2'd1;
	localparam logic [1:0] WHY_REFUSED = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_FIRST_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_BLOCK_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_MAX_REQUESTS  = 2'd2;
	localparam logic [1:0] REG_BLOCK_SIZE    = 2'd3;

	// Register reset values
	localparam logic [7:0]  RST_FIRST_TIMEOUT = 8'd5;
	localparam logic [7:0]  RST_BLOCK_TIMEOUT = 8'd3;
	localparam logic [3:0]  RST_MAX_REQUESTS  = 4'd3;
	localparam logic [10:0] RST_BLOCK_SIZE    = 11'd512;

	// Depth of the queue between front and back
	localparam int FIFO_DEPTH = 4;

	// Most results one input word can cause
	localparam int MAX_RESULTS = 3;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_ACTIVE = 4'b0010,
		PH_DONE   = 4'b0100,
		PH_FAILED = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic        from_server;
		logic [10:0] packet_length;
		logic [15:0] packet_opcode;
		logic [15:0] packet_block;
		logic        sink_accepts;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] block_id;
		logic [10:0] data_bytes;
		logic        via_server_port;
		logic [1:0]  fail_reason;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [7:0]  first_block_timeout;
		logic [7:0]  block_timeout;
		logic [3:0]  max_requests;
		logic [10:0] block_size;
	} cfg_t;

	// All results of one input word, last one flagged
	typedef struct packed {
		out_word_t [MAX_RESULTS-1:0] res;
	} bundle_t;

endpackage

### hdl/tftprc_front.sv
module tftprc_front import tftprc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_word_t item,
	input  cfg_t     cfg,
	output logic     push,
	output bundle_t  bundle
);

	phase_t      phase_q, phase_d;
	logic [15:0] expected_q, expected_d;
	logic [3:0]  requests_q, requests_d;
	logic [7:0]  seconds_q, seconds_d;
	logic        bound_q, bound_d;

	out_word_t [MAX_RESULTS-1:0] res;
	logic [1:0]  n_res;
	logic [7:0]  limit;
	logic [7:0]  seconds_inc;
	logic [15:0] prev_block;
	logic        is_next, is_prev, pkt_valid;
	logic [10:0] nbytes;

	function automatic out_word_t mk(input logic [2:0] act, input logic [15:0] blk,
		input logic [10:0] bytes, input logic via, input logic [1:0] why);
		out_word_t w;
		w.action          = act;
		w.block_id        = blk;
		w.data_bytes      = bytes;
		w.via_server_port = via;
		w.fail_reason     = why;
		w.last            = 1'b0;
		return w;
	endfunction

	// Classify the word and work out the next state and its results
	always_comb begin
		phase_d    = phase_q;
		expected_d = expected_q;
		requests_d = requests_q;
		seconds_d  = seconds_q;
		bound_d    = bound_q;
		res        = '0;
		n_res      = 2'd0;

		limit       = bound_q ? cfg.block_timeout : cfg.first_block_timeout;
		seconds_inc = (seconds_q == 8'hFF) ? seconds_q : seconds_q + 8'd1;
		prev_block  = expected_q - 16'd1;
		is_next     = item.packet_block == expected_q;
		is_prev     = bound_q && (item.packet_block == prev_block);
		pkt_valid   = item.from_server && (item.packet_length >= HDR_BYTES) &&
			(item.packet_opcode == TFTP_DATA) && (is_next || is_prev);
		nbytes      = item.packet_length - HDR_BYTES;

		case (item.operation)
			OP_START: begin
				phase_d    = PH_ACTIVE;
				expected_d = 16'd1;
				requests_d = 4'd1;
				seconds_d  = 8'd0;
				bound_d    = 1'b0;
				res[0]     = mk(ACT_RRQ, 16'd0, 11'd0, 1'b0, WHY_TIMEOUT);
				n_res      = 2'd1;
			end
			OP_TICK: begin
				if (phase_q == PH_ACTIVE) begin
					seconds_d = seconds_inc;
					if (seconds_inc > limit) begin
						if (!bound_q && (requests_q < cfg.max_requests)) begin
							requests_d = requests_q + 4'd1;
							seconds_d  = 8'd0;
							res[0]     = mk(ACT_RRQ, 16'd0, 11'd0, 1'b0, WHY_TIMEOUT);
						end else begin
							phase_d = PH_FAILED;
							res[0]  = mk(ACT_FAIL, 16'd0, 11'd0, 1'b0, WHY_TIMEOUT);
						end
						n_res = 2'd1;
					end
				end
			end
			OP_PACKET: begin
				if (phase_q == PH_ACTIVE) begin
					if (!pkt_valid) begin
						if (item.from_server && (item.packet_length >= ERR_MIN_BYTES) &&
							(item.packet_opcode == TFTP_ERROR)) begin
							phase_d = PH_FAILED;
							res[0]  = mk(ACT_FAIL, 16'd0, 11'd0, 1'b0, WHY_ERROR);
							n_res   = 2'd1;
						end else if (!item.from_server && !bound_q) begin
							res[0] = mk(ACT_REBIND, 16'd0, 11'd0, 1'b0, WHY_TIMEOUT);
							n_res  = 2'd1;
						end
					end else begin
						bound_d = 1'b1;
						if (is_next) begin
							res[0] = mk(ACT_DELIVER, item.packet_block, nbytes, 1'b0,
								WHY_TIMEOUT);
							if (!item.sink_accepts) begin
								phase_d = PH_FAILED;
								res[1]  = mk(ACT_FAIL, 16'd0, 11'd0, 1'b0, WHY_REFUSED);
								n_res   = 2'd2;
							end else begin
								expected_d = expected_q + 16'd1;
								seconds_d  = 8'd0;
								res[1]     = mk(ACT_ACK, item.packet_block, 11'd0, 1'b1,
									WHY_TIMEOUT);
								if (nbytes < cfg.block_size) begin
									phase_d = PH_DONE;
									res[2]  = mk(ACT_DONE, 16'd0, 11'd0, 1'b0, WHY_TIMEOUT);
									n_res   = 2'd3;
								end else begin
									n_res = 2'd2;
								end
							end
						end else begin
							// duplicate of the previous block: ACK it again
							res[0] = mk(ACT_ACK, item.packet_block, 11'd0, 1'b1, WHY_TIMEOUT);
							n_res  = 2'd1;
						end
					end
				end
			end
			default: begin
			end
		endcase

		// Flag the final result of this word
		case (n_res)
			2'd1: res[0].last = 1'b1;
			2'd2: res[1].last = 1'b1;
			2'd3: res[2].last = 1'b1;
			default: begin
			end
		endcase
	end

	assign push       = accept && (n_res != 2'd0);
	assign bundle.res = res;

	// Commit the state on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			expected_q <= 16'd1;
			requests_q <= 4'd0;
			seconds_q  <= 8'd0;
			bound_q    <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_d;
			expected_q <= expected_d;
			requests_q <= requests_d;
			seconds_q  <= seconds_d;
			bound_q    <= bound_d;
		end
	end

endmodule

### hdl/tftprc_fifo.sv
module tftprc_fifo import tftprc_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t wr_data,
	input  logic    pop,
	output bundle_t rd_data,
	output logic    full,
	output logic    empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t       slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = slot_q[rd_ptr_q];

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### hdl/tftprc_back.sv
module tftprc_back import tftprc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  bundle_t   head,
	input  logic      empty,
	input  logic      result_stall,
	output logic      pop,
	output logic      result_valid,
	output out_word_t result
);

	logic [1:0] idx_q;
	logic       take;

	assign result_valid = !empty;
	assign result       = head.res[idx_q];
	assign take         = result_valid && !result_stall;
	assign pop          = take && result.last;

	// Step through the results of the head entry, drop it after its last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (take) begin
			idx_q <= result.last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

### hdl/tftp_read_client_control_unit.sv
// TFTP read client control: one input word accepted per cycle while the queue has room.
// Results are registered in the queue and leave one result word per cycle while result_stall
// is low; a word causing 0 to 3 results sends them in turn through the single result port.
// A queue of FIFO_DEPTH entries decouples input acceptance from output stalls.
// Reset (arst_n low, asynchronous) empties the queue, sets phase idle, expected block 1,
// and loads the registers with their default values.
module tftp_read_client_control_unit import tftprc_pkg::*; #(
	parameter int FIFO_DEPTH_P = FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  in_word_t    item,
	output logic        result_valid,
	input  logic        result_stall,
	output out_word_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t    cfg_q;
	logic    accept;
	logic    push, pop, full, empty;
	bundle_t push_data, head;
	logic    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_block_timeout <= RST_FIRST_TIMEOUT;
			cfg_q.block_timeout       <= RST_BLOCK_TIMEOUT;
			cfg_q.max_requests        <= RST_MAX_REQUESTS;
			cfg_q.block_size          <= RST_BLOCK_SIZE;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_FIRST_TIMEOUT: cfg_q.first_block_timeout <= pwdata[7:0];
				REG_BLOCK_TIMEOUT: cfg_q.block_timeout       <= pwdata[7:0];
				REG_MAX_REQUESTS:  cfg_q.max_requests        <= pwdata[3:0];
				REG_BLOCK_SIZE:    cfg_q.block_size          <= pwdata[10:0];
				default: begin
				end
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		case (paddr[3:2])
			REG_FIRST_TIMEOUT: prdata = {24'd0, cfg_q.first_block_timeout};
			REG_BLOCK_TIMEOUT: prdata = {24'd0, cfg_q.block_timeout};
			REG_MAX_REQUESTS:  prdata = {28'd0, cfg_q.max_requests};
			REG_BLOCK_SIZE:    prdata = {21'd0, cfg_q.block_size};
			default:           prdata = 32'd0;
		endcase
	end

	assign item_stall = full;
	assign accept     = item_valid && !full;

	tftprc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cfg    (cfg_q),
		.push   (push),
		.bundle (push_data)
	);

	tftprc_fifo #(
		.DEPTH (FIFO_DEPTH_P)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_data),
		.pop     (pop),
		.rd_data (head),
		.full    (full),
		.empty   (empty)
	);

	tftprc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.result_stall (result_stall),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

### hdl/tftprc_checker.sv
`include "tftp_read_client_control_unit_assert.svh"

module tftprc_checker import tftprc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      result_valid,
	input logic      result_stall,
	input out_word_t result
);

	// Hold a stalled result word
	`TFTPRC_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

	// Only defined actions leave the block
	`TFTPRC_ASSERT_NOW(a_action_range, clk, arst_n, result_valid, result.action <= ACT_FAIL, "undefined action")

	// ACKs go through the server port, nothing else does
	`TFTPRC_ASSERT_NOW(a_via_ack, clk, arst_n, result_valid, result.via_server_port == (result.action == ACT_ACK), "port choice does not match action")

	// Fail reason only on failures, and only a defined one
	`TFTPRC_ASSERT_NOW(a_fail_reason, clk, arst_n, result_valid, (result.action == ACT_FAIL) ? (result.fail_reason != 2'd3) : (result.fail_reason == WHY_TIMEOUT), "bad fail reason")

	// Terminal results end the burst of their input word
	`TFTPRC_ASSERT_NOW(a_terminal_last, clk, arst_n, result_valid && (result.action == ACT_FAIL || result.action == ACT_DONE || result.action == ACT_RRQ || result.action == ACT_REBIND), result.last, "terminal result not flagged last")

endmodule

bind tftp_read_client_control_unit tftprc_checker u_tftprc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
